### hdl/datf_pkg.sv
// ----------------------------------------------------------------------------
// datf_pkg
// shared widths, register indexes and reset values of the detection argmax
// threshold filter
// ----------------------------------------------------------------------------
package datf_pkg;

  localparam int unsigned ScoreW    = 16;
  localparam int unsigned RawW      = 16;
  localparam int unsigned BoxW      = 20;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned ClassW    = 8;
  localparam int unsigned ExclW     = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 104;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgScoreThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxScale       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRoiEnable      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRoiXLow        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRoiYLow        = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRoiXHigh       = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRoiYHigh       = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgExcludedClass  = 3'd7;

  // reset values
  localparam logic [ScaleW-1:0]      BoxScaleRst = 16'd4096;
  localparam logic signed [BoxW-1:0] RoiHighRst  = 20'sd524287;
  localparam logic [ExclW-1:0]       ExclRst     = 9'd256;

  typedef struct packed {
    logic signed [RawW-1:0]   y_max;
    logic signed [RawW-1:0]   x_max;
    logic signed [RawW-1:0]   y_min;
    logic signed [RawW-1:0]   x_min;
    logic signed [ScoreW-1:0] score;
  } in_item_t;

  typedef struct packed {
    logic signed [BoxW-1:0]   y_max;
    logic signed [BoxW-1:0]   x_max;
    logic signed [BoxW-1:0]   y_min;
    logic signed [BoxW-1:0]   x_min;
    logic signed [ScoreW-1:0] best;
    logic [ClassW-1:0]        cls;
  } out_item_t;

endpackage

### hdl/detection_argmax_threshold_filter.sv
// ----------------------------------------------------------------------------
// detection_argmax_threshold_filter
// running argmax over class scores with threshold, region and class filter
// ----------------------------------------------------------------------------
// Takes one class score per transaction and keeps the best score and its
// class; tlast marks the last class of a prediction and carries the four raw
// box edges. On that transaction the box is scaled by box_scale (Q4.12 by
// default) with floor rounding and 20-bit saturation, and one detection is
// sent if the best score exceeds the threshold, the box is inside the region
// (when enabled) and the class is not the excluded one. One transaction is
// taken every cycle while results are taken; a result is valid in the cycle
// after its last class leaves the input register. The rate is set by the
// combinational running max update feeding the output register. The user
// must write configuration only while the block is idle; it is not enforced.
module detection_argmax_threshold_filter
  import datf_pkg::*;
#(
  parameter int unsigned MAX_CLASSES     = 256,
  parameter int unsigned SCALE_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // class_score, raw_x_min, raw_y_min, raw_x_max, raw_y_max
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // class_index, best_score, box_x_min, box_y_min, box_x_max, box_y_max
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned PosW = $clog2(MAX_CLASSES);
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_CLASSES - 1);
  localparam int unsigned ProdW = RawW + ScaleW + 1;
  localparam logic signed [ProdW-1:0] SatHi = ProdW'(524287);
  localparam logic signed [ProdW-1:0] SatLo = -ProdW'(524288);

  // configuration registers
  logic signed [ScoreW-1:0] score_threshold_q;
  logic [ScaleW-1:0]        box_scale_q;
  logic                     roi_enable_q;
  logic signed [BoxW-1:0]   roi_x_low_q, roi_y_low_q, roi_x_high_q, roi_y_high_q;
  logic [ExclW-1:0]         excluded_class_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_threshold_q <= '0;
      box_scale_q       <= BoxScaleRst;
      roi_enable_q      <= 1'b0;
      roi_x_low_q       <= '0;
      roi_y_low_q       <= '0;
      roi_x_high_q      <= RoiHighRst;
      roi_y_high_q      <= RoiHighRst;
      excluded_class_q  <= ExclRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScoreThreshold: score_threshold_q <= cfg_data_i[ScoreW-1:0];
        CfgBoxScale:       box_scale_q       <= cfg_data_i[ScaleW-1:0];
        CfgRoiEnable:      roi_enable_q      <= cfg_data_i[0];
        CfgRoiXLow:        roi_x_low_q       <= cfg_data_i[BoxW-1:0];
        CfgRoiYLow:        roi_y_low_q       <= cfg_data_i[BoxW-1:0];
        CfgRoiXHigh:       roi_x_high_q      <= cfg_data_i[BoxW-1:0];
        CfgRoiYHigh:       roi_y_high_q      <= cfg_data_i[BoxW-1:0];
        CfgExcludedClass:  excluded_class_q  <= cfg_data_i[ExclW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic     s1_valid_q;
  logic     s1_last_q;
  in_item_t s1_item_q;
  logic     s1_adv;
  logic     out_valid_q;
  out_item_t out_item_q;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item_q <= in_item_t'(s_axis_tdata);
      s1_last_q <= s_axis_tlast;
    end
  end

  // running argmax
  logic signed [ScoreW-1:0] best_q, best_d;
  logic [PosW-1:0]          cls_q, cls_d, pos_q, pos_d;
  logic                     take;
  logic signed [ScoreW-1:0] cur_best;
  logic [PosW-1:0]          cur_cls;

  assign take     = (pos_q == '0) || (s1_item_q.score > best_q);
  assign cur_best = take ? s1_item_q.score : best_q;
  assign cur_cls  = take ? pos_q : cls_q;

  always_comb begin
    best_d = best_q;
    cls_d  = cls_q;
    pos_d  = pos_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        best_d = '0;
        cls_d  = '0;
        pos_d  = '0;
      end else begin
        best_d = cur_best;
        cls_d  = cur_cls;
        if (pos_q != PosLast) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      cls_q  <= '0;
      pos_q  <= '0;
    end else begin
      best_q <= best_d;
      cls_q  <= cls_d;
      pos_q  <= pos_d;
    end
  end

  // box scaling, floor shift and saturation
  function automatic logic signed [BoxW-1:0] scale_edge(
    input logic signed [RawW-1:0] raw,
    input logic [ScaleW-1:0]      scale
  );
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] shifted;
    logic signed [BoxW-1:0]  res;
    prod    = ProdW'(raw) * ProdW'($signed({1'b0, scale}));
    shifted = prod >>> SCALE_FRAC_BITS;
    if (shifted > SatHi) begin
      res = BoxW'(SatHi);
    end else if (shifted < SatLo) begin
      res = BoxW'(SatLo);
    end else begin
      res = shifted[BoxW-1:0];
    end
    return res;
  endfunction

  out_item_t res;
  logic      roi_fail;
  logic      keep;

  always_comb begin
    res.cls   = ClassW'(cur_cls);
    res.best  = cur_best;
    res.x_min = scale_edge(s1_item_q.x_min, box_scale_q);
    res.y_min = scale_edge(s1_item_q.y_min, box_scale_q);
    res.x_max = scale_edge(s1_item_q.x_max, box_scale_q);
    res.y_max = scale_edge(s1_item_q.y_max, box_scale_q);
    roi_fail  = roi_enable_q && ((res.x_min < roi_x_low_q) || (res.x_max > roi_x_high_q) ||
                                 (res.y_min < roi_y_low_q) || (res.y_max > roi_y_high_q));
    keep      = (cur_best > score_threshold_q) && !roi_fail &&
                ({1'b0, res.cls} != excluded_class_q);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_last_q && keep;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("class position beyond last class");

  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (pos_q == '0) && (best_q == '0) && (cls_q == '0))
    else $error("running state not restarted after last class");

  a_no_mid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_last_q) |=> !out_valid_q)
    else $error("result raised by a class that is not the last");
`endif

endmodule
